/* hw/rtl/stps_pkg.sv */
// Shared types, constants and helper functions for the Stanley steering block.
// Used by stps_cordic, stps_ctrl, stps_dp and stanley_path_steering.
package stps_pkg;

    localparam int CORDIC_W     = 50;
    localparam int ANG_W        = 32;
    localparam int STEP_W       = 5;
    localparam int CORDIC_STEPS = 28;

    // Angles inside the CORDIC are in units of 2^-28 rad.
    localparam logic signed [ANG_W-1:0] HALF_PI_A = 32'sd421657428;
    localparam logic signed [ANG_W-1:0] PI_A      = 32'sd843314856;
    localparam logic signed [ANG_W-1:0] TWO_PI_A  = 32'sd1686629712;

    localparam logic signed [17:0] PI_Q13     = 18'sd25736;
    localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;

    localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;

    localparam logic CFG_GAIN  = 1'b0;
    localparam logic CFG_COUNT = 1'b1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_STEER = 1'b1;

    typedef struct packed {
        logic               op;
        logic [7:0]         point_index;
        logic signed [19:0] pos_x;
        logic signed [19:0] pos_y;
        logic signed [15:0] yaw;
        logic signed [15:0] speed;
    } item_t;

    typedef struct packed {
        logic signed [16:0] steer_angle;
        logic [7:0]         target_index;
    } result_t;

    typedef enum logic [1:0] {
        RD_SCAN = 2'd0,
        RD_SEG  = 2'd1,
        RD_NEXT = 2'd2,
        RD_TGT  = 2'd3
    } rd_sel_t;

    typedef enum logic [1:0] {
        CS_HEAD = 2'd0,
        CS_ROT  = 2'd1,
        CS_CTE  = 2'd2
    } cordic_sel_t;

    typedef enum logic {
        CM_VECTOR = 1'b0,
        CM_ROTATE = 1'b1
    } cordic_mode_t;

    typedef struct packed {
        logic        capture;
        logic        write_pt;
        logic        scan_run;
        logic        pick;
        rd_sel_t     rd_sel;
        logic        lat_a;
        logic        lat_b;
        logic        lat_c;
        logic        cordic_start;
        cordic_sel_t csel;
        logic        cap_head;
        logic        cap_rot;
        logic        mul1;
        logic        mul2;
        logic        mul3;
        logic        cap_cte;
        logic        out_load;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic cordic_done;
    } sts_t;

    // atan(2^-i) in units of 2^-28 rad, rounded to nearest.
    function automatic logic signed [ANG_W-1:0] atan_lut(input logic [STEP_W-1:0] i);
        logic signed [ANG_W-1:0] v;
        case (i)
            5'd0:    v = 32'sd210828714;
            5'd1:    v = 32'sd124459457;
            5'd2:    v = 32'sd65760959;
            5'd3:    v = 32'sd33381290;
            5'd4:    v = 32'sd16755422;
            5'd5:    v = 32'sd8385879;
            5'd6:    v = 32'sd4193963;
            5'd7:    v = 32'sd2097109;
            5'd8:    v = 32'sd1048571;
            5'd9:    v = 32'sd524287;
            5'd10:   v = 32'sd262144;
            5'd11:   v = 32'sd131072;
            5'd12:   v = 32'sd65536;
            5'd13:   v = 32'sd32768;
            5'd14:   v = 32'sd16384;
            5'd15:   v = 32'sd8192;
            5'd16:   v = 32'sd4096;
            5'd17:   v = 32'sd2048;
            5'd18:   v = 32'sd1024;
            5'd19:   v = 32'sd512;
            5'd20:   v = 32'sd256;
            5'd21:   v = 32'sd128;
            5'd22:   v = 32'sd64;
            5'd23:   v = 32'sd32;
            5'd24:   v = 32'sd16;
            5'd25:   v = 32'sd8;
            5'd26:   v = 32'sd4;
            5'd27:   v = 32'sd2;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    // Round an internal angle to Q3.13, half away from zero.
    function automatic logic signed [17:0] rnd15(input logic signed [ANG_W-1:0] v);
        logic signed [ANG_W:0] w;
        logic signed [ANG_W:0] mag;
        logic signed [ANG_W:0] q;
        w   = {v[ANG_W-1], v};
        mag = (w < 0) ? -w : w;
        q   = (mag + 33'sd16384) >>> 15;
        if (w < 0)
        begin
            q = -q;
        end
        return q[17:0];
    endfunction

endpackage

/* hw/rtl/stps_cordic.sv */
// Shared iterative CORDIC unit, one micro-rotation per cycle, vectoring or rotation.
// Depends on stps_pkg for widths, the arctangent table and mode codes.
module stps_cordic
    import stps_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  cordic_mode_t               mode,
    input  logic signed [CORDIC_W-1:0] x_in,
    input  logic signed [CORDIC_W-1:0] y_in,
    input  logic signed [ANG_W-1:0]    z_in,
    output logic                       done,
    output logic signed [CORDIC_W-1:0] x_out,
    output logic signed [ANG_W-1:0]    z_out
);

    logic signed [CORDIC_W-1:0] x_reg, x_next;
    logic signed [CORDIC_W-1:0] y_reg, y_next;
    logic signed [ANG_W-1:0]    z_reg, z_next;
    logic [STEP_W-1:0]          step_reg, step_next;
    logic                       run_reg, run_next;
    logic                       done_reg, done_next;
    logic                       zero_reg, zero_next;
    cordic_mode_t               mode_reg, mode_next;

    logic signed [CORDIC_W-1:0] xs;
    logic signed [CORDIC_W-1:0] ys;
    logic                       cw;

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        step_next = step_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        zero_next = zero_reg;
        mode_next = mode_reg;
        xs        = x_reg >>> step_reg;
        ys        = y_reg >>> step_reg;
        cw        = (mode_reg == CM_VECTOR) ? (y_reg > 0) : (z_reg < 0);

        if (start)
        begin
            mode_next = mode;
            run_next  = 1'b1;
            step_next = '0;
            zero_next = 1'b0;
            x_next    = x_in;
            y_next    = y_in;
            z_next    = z_in;
            if (mode == CM_VECTOR)
            begin
                zero_next = (x_in == 0) && (y_in == 0);
                z_next    = '0;
                // Fold the left half plane onto the right half with a quarter turn.
                if (x_in < 0)
                begin
                    if (y_in >= 0)
                    begin
                        x_next = y_in;
                        y_next = -x_in;
                        z_next = HALF_PI_A;
                    end
                    else
                    begin
                        x_next = -y_in;
                        y_next = x_in;
                        z_next = -HALF_PI_A;
                    end
                end
            end
            else
            begin
                if (z_in > HALF_PI_A)
                begin
                    x_next = -y_in;
                    y_next = x_in;
                    z_next = z_in - HALF_PI_A;
                end
                else if (z_in < -HALF_PI_A)
                begin
                    x_next = y_in;
                    y_next = -x_in;
                    z_next = z_in + HALF_PI_A;
                end
            end
        end
        else if (run_reg)
        begin
            if (cw)
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + atan_lut(step_reg);
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - atan_lut(step_reg);
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(CORDIC_STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        zero_reg <= zero_next;
        mode_reg <= mode_next;
    end

    assign done  = done_reg;
    assign x_out = x_reg;
    assign z_out = zero_reg ? '0 : z_reg;

endmodule

/* hw/rtl/stps_ctrl.sv */
// Sequencing state machine for the Stanley steering block.
// Depends on stps_pkg for the command and status structs.
module stps_ctrl
    import stps_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic item_valid,
    input  logic item_op,
    output logic item_ready,
    output logic result_valid,
    input  logic result_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [15:0] {
        S_IDLE = 16'h0001,
        S_LOAD = 16'h0002,
        S_SCAN = 16'h0004,
        S_PICK = 16'h0008,
        S_RD0  = 16'h0010,
        S_RD1  = 16'h0020,
        S_RD2  = 16'h0040,
        S_RD3  = 16'h0080,
        S_HEAD = 16'h0100,
        S_ROT  = 16'h0200,
        S_MUL1 = 16'h0400,
        S_MUL2 = 16'h0800,
        S_MUL3 = 16'h1000,
        S_CGO  = 16'h2000,
        S_CTE  = 16'h4000,
        S_DONE = 16'h8000
    } state_t;

    state_t state_reg, state_next;
    logic   valid_reg, valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = (item_op == OP_STEER) ? S_SCAN : S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.write_pt = 1'b1;
                state_next   = S_IDLE;
            end
            S_SCAN:
            begin
                cmd.scan_run = 1'b1;
                cmd.rd_sel   = RD_SCAN;
                if (sts.scan_done)
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                cmd.pick   = 1'b1;
                state_next = S_RD0;
            end
            S_RD0:
            begin
                cmd.rd_sel = RD_SEG;
                state_next = S_RD1;
            end
            S_RD1:
            begin
                cmd.rd_sel = RD_NEXT;
                cmd.lat_a  = 1'b1;
                state_next = S_RD2;
            end
            S_RD2:
            begin
                cmd.rd_sel = RD_TGT;
                cmd.lat_b  = 1'b1;
                state_next = S_RD3;
            end
            S_RD3:
            begin
                cmd.lat_c        = 1'b1;
                cmd.cordic_start = 1'b1;
                cmd.csel         = CS_HEAD;
                state_next       = S_HEAD;
            end
            S_HEAD:
            begin
                cmd.csel = CS_ROT;
                if (sts.cordic_done)
                begin
                    cmd.cap_head     = 1'b1;
                    cmd.cordic_start = 1'b1;
                    state_next       = S_ROT;
                end
            end
            S_ROT:
            begin
                cmd.csel = CS_ROT;
                if (sts.cordic_done)
                begin
                    cmd.cap_rot = 1'b1;
                    state_next  = S_MUL1;
                end
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_MUL3;
            end
            S_MUL3:
            begin
                cmd.mul3   = 1'b1;
                state_next = S_CGO;
            end
            S_CGO:
            begin
                cmd.csel         = CS_CTE;
                cmd.cordic_start = 1'b1;
                state_next       = S_CTE;
            end
            S_CTE:
            begin
                cmd.csel = CS_CTE;
                if (sts.cordic_done)
                begin
                    cmd.cap_cte = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                // The output register must be free or emptying this cycle.
                if (!valid_reg || result_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.out_load)
        begin
            valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign result_valid = valid_reg;

endmodule

/* hw/rtl/stps_dp.sv */
// Datapath: path table, nearest-point scan, angle arithmetic and result register.
// Depends on stps_pkg and instantiates stps_cordic.
module stps_dp
    import stps_pkg::*;
#(
    parameter int MAX_POINTS = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  item_t       item,
    input  cmd_t        cmd,
    output sts_t        sts,
    output result_t     result
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int NW = AW + 1;

    item_t item_reg;
    logic [15:0] gain_reg;
    logic [8:0]  count_reg;

    logic signed [19:0] mem_x [MAX_POINTS];
    logic signed [19:0] mem_y [MAX_POINTS];
    logic signed [19:0] rdx_reg;
    logic signed [19:0] rdy_reg;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic               slot_ok;

    logic [NW-1:0] n_sat;
    logic [NW-1:0] n_last;
    logic [NW-1:0] n_prev;

    logic [NW-1:0] cnt_reg;
    logic          issue;
    logic          rd_v_reg;
    logic [AW-1:0] rd_idx_reg;
    logic          sq_v_reg;
    logic [AW-1:0] sq_idx_reg;
    logic [41:0]   sqx_reg;
    logic [41:0]   sqy_reg;
    logic [42:0]   best_d_reg;
    logic [AW-1:0] best_idx_reg;
    logic signed [20:0] ex;
    logic signed [20:0] ey;
    logic signed [41:0] sqx_c;
    logic signed [41:0] sqy_c;
    logic [42:0]   sq_dist;

    logic [AW-1:0] cur_reg;
    logic [AW-1:0] tgt_reg;
    logic [AW-1:0] seg_reg;
    logic [AW-1:0] tmax;
    logic [AW-1:0] tgt_c;
    logic [AW-1:0] seg_c;

    logic signed [19:0] ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;

    logic signed [CORDIC_W-1:0] c_x_in;
    logic signed [CORDIC_W-1:0] c_y_in;
    logic signed [ANG_W-1:0]    c_z_in;
    cordic_mode_t               c_mode;
    logic                       c_done;
    logic signed [CORDIC_W-1:0] c_x_out;
    logic signed [ANG_W-1:0]    c_z_out;
    logic signed [20:0]         hdx, hdy, rdxd, rdyd;

    logic signed [17:0]    th_e_reg;
    logic signed [17:0]    th_d_reg;
    logic signed [17:0]    th_c;
    logic signed [ANG_W-1:0] a_reg;
    logic signed [ANG_W+1:0] a_c;
    logic signed [31:0]    xr_reg;
    logic signed [63:0]    prod_reg;
    logic signed [31:0]    e_reg;
    logic signed [48:0]    num_reg;
    logic [63:0]           pmag;
    logic [63:0]           pq;
    logic signed [31:0]    e_c;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= 16'd256;
            count_reg <= 9'd2;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GAIN:  gain_reg  <= cfg_data;
                CFG_COUNT: count_reg <= cfg_data[8:0];
                default:   gain_reg  <= gain_reg;
            endcase
        end
    end

    always_comb
    begin
        if (count_reg < 9'd2)
        begin
            n_sat = NW'(2);
        end
        else if (32'(count_reg) > MAX_POINTS)
        begin
            n_sat = NW'(MAX_POINTS);
        end
        else
        begin
            n_sat = NW'(count_reg);
        end
        n_last = n_sat - NW'(1);
        n_prev = n_sat - NW'(2);
    end

    // Path table: one write and one registered read per cycle.
    assign slot_ok = (32'(item_reg.point_index) < MAX_POINTS);
    assign wr_addr = AW'(item_reg.point_index);

    always_comb
    begin
        case (cmd.rd_sel)
            RD_SCAN: rd_addr = cnt_reg[AW-1:0];
            RD_SEG:  rd_addr = seg_reg;
            RD_NEXT: rd_addr = AW'(seg_reg + 1'b1);
            RD_TGT:  rd_addr = tgt_reg;
            default: rd_addr = cnt_reg[AW-1:0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_pt && slot_ok)
        begin
            mem_x[wr_addr] <= item_reg.pos_x;
            mem_y[wr_addr] <= item_reg.pos_y;
        end
        rdx_reg <= mem_x[rd_addr];
        rdy_reg <= mem_y[rd_addr];
    end

    // Nearest-point scan: address, read, square, compare.
    assign issue   = cmd.scan_run && (cnt_reg < n_sat);
    assign ex      = 21'(rdx_reg) - 21'(item_reg.pos_x);
    assign ey      = 21'(rdy_reg) - 21'(item_reg.pos_y);
    assign sqx_c   = ex * ex;
    assign sqy_c   = ey * ey;
    assign sq_dist = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            rd_v_reg <= 1'b0;
            sq_v_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                cnt_reg <= '0;
            end
            else if (issue)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            rd_v_reg <= issue;
            sq_v_reg <= rd_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= cnt_reg[AW-1:0];
        sq_idx_reg <= rd_idx_reg;
        sqx_reg    <= 42'(sqx_c);
        sqy_reg    <= 42'(sqy_c);
        if (sq_v_reg && ((sq_idx_reg == '0) || (sq_dist < best_d_reg)))
        begin
            best_d_reg   <= sq_dist;
            best_idx_reg <= sq_idx_reg;
        end
    end

    assign sts.scan_done = cmd.scan_run && (cnt_reg == n_sat) && !rd_v_reg && !sq_v_reg;

    // Target choice: never behind the previous target, clamped to the path end.
    always_comb
    begin
        tmax  = (best_idx_reg > cur_reg) ? best_idx_reg : cur_reg;
        tgt_c = ({1'b0, tmax} > n_last) ? n_last[AW-1:0] : tmax;
        seg_c = ({1'b0, tgt_c} < n_last) ? tgt_c : n_prev[AW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg <= '0;
        end
        else if (cmd.write_pt)
        begin
            cur_reg <= '0;
        end
        else if (cmd.pick)
        begin
            cur_reg <= tgt_c;
        end
    end

    // CORDIC operands for the segment heading, the lateral error and the steer term.
    always_comb
    begin
        hdx = 21'(bx_reg) - 21'(ax_reg);
        hdy = 21'(by_reg) - 21'(ay_reg);
        rdxd = 21'(cx_reg) - 21'(item_reg.pos_x);
        rdyd = 21'(cy_reg) - 21'(item_reg.pos_y);
        case (cmd.csel)
            CS_HEAD:
            begin
                c_mode = CM_VECTOR;
                c_x_in = CORDIC_W'(hdx);
                c_y_in = CORDIC_W'(hdy);
                c_z_in = '0;
            end
            CS_ROT:
            begin
                c_mode = CM_ROTATE;
                c_x_in = CORDIC_W'(signed'({rdxd, 8'b0}));
                c_y_in = CORDIC_W'(signed'({rdyd, 8'b0}));
                c_z_in = a_reg;
            end
            CS_CTE:
            begin
                c_mode = CM_VECTOR;
                c_x_in = CORDIC_W'(signed'({item_reg.speed, 16'b0}));
                c_y_in = CORDIC_W'(num_reg);
                c_z_in = '0;
            end
            default:
            begin
                c_mode = CM_VECTOR;
                c_x_in = '0;
                c_y_in = '0;
                c_z_in = '0;
            end
        endcase
    end

    stps_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.cordic_start),
        .mode  (c_mode),
        .x_in  (c_x_in),
        .y_in  (c_y_in),
        .z_in  (c_z_in),
        .done  (c_done),
        .x_out (c_x_out),
        .z_out (c_z_out)
    );

    assign sts.cordic_done = c_done;

    // Heading error and the rotation angle -(yaw + pi/2), both wrapped to one turn.
    always_comb
    begin
        th_c = rnd15(c_z_out) - 18'(item_reg.yaw);
        if (th_c > PI_Q13)
        begin
            th_c = th_c - TWO_PI_Q13;
        end
        else if (th_c < -PI_Q13)
        begin
            th_c = th_c + TWO_PI_Q13;
        end
        a_c = -((34'(item_reg.yaw) <<< 15) + 34'(HALF_PI_A));
        if (a_c > 34'(PI_A))
        begin
            a_c = a_c - 34'(TWO_PI_A);
        end
        else if (a_c < -34'(PI_A))
        begin
            a_c = a_c + 34'(TWO_PI_A);
        end
    end

    // Gain correction of the rotated x, rounded half away from zero.
    always_comb
    begin
        pmag = (prod_reg < 0) ? 64'(-prod_reg) : 64'(prod_reg);
        pq   = (pmag + 64'd536870912) >> 30;
        e_c  = (prod_reg < 0) ? -32'(pq) : 32'(pq);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
        end
        // The rotation angle depends only on yaw, so it is ready well before
        // the rotation pass starts.
        if (cmd.pick)
        begin
            tgt_reg <= tgt_c;
            seg_reg <= seg_c;
            a_reg   <= a_c[ANG_W-1:0];
        end
        if (cmd.lat_a)
        begin
            ax_reg <= rdx_reg;
            ay_reg <= rdy_reg;
        end
        if (cmd.lat_b)
        begin
            bx_reg <= rdx_reg;
            by_reg <= rdy_reg;
        end
        if (cmd.lat_c)
        begin
            cx_reg <= rdx_reg;
            cy_reg <= rdy_reg;
        end
        if (cmd.cap_head)
        begin
            th_e_reg <= th_c;
        end
        if (cmd.cap_rot)
        begin
            xr_reg <= 32'(c_x_out);
        end
        if (cmd.mul1)
        begin
            prod_reg <= xr_reg * CORDIC_GAIN_Q30;
        end
        if (cmd.mul2)
        begin
            e_reg <= e_c;
        end
        if (cmd.mul3)
        begin
            num_reg <= signed'({1'b0, gain_reg}) * e_reg;
        end
        if (cmd.cap_cte)
        begin
            th_d_reg <= rnd15(c_z_out);
        end
        if (cmd.out_load)
        begin
            result.steer_angle  <= 17'(th_e_reg + th_d_reg);
            result.target_index <= 8'(tgt_reg);
        end
    end

endmodule

/* hw/rtl/stanley_path_steering.sv */
// Stanley path-tracking steering block: top level.
// A load word gives no result. In a steer word the table scan reads one point
// per cycle and the shared CORDIC unit runs three 28-step passes.
// One word is in work at a time; a finished result waits in the output register.
// Reset (rst_n, asynchronous, active low) clears control, gain, count and target.
module stanley_path_steering
    import stps_pkg::*;
#(
    parameter int MAX_POINTS = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  item_t       item,
    output logic        result_valid,
    input  logic        result_ready,
    output result_t     result,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    stps_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_op      (item.op),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .sts          (sts),
        .cmd          (cmd)
    );

    stps_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .cmd       (cmd),
        .sts       (sts),
        .result    (result)
    );

`ifndef ASSERT_OFF
    // A load word never produces a result.
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item.op == OP_LOAD) |=> !$rose(result_valid))
        else $error("result raised after a load word");

    // An accepted word keeps the block busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("ready stayed high after accepting a word");

    // A result is only produced from a busy block.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(!item_ready))
        else $error("result appeared while the block was idle");

    // Scan done is raised only during the scan phase.
    a_scan_drained: assert property (@(posedge clk) disable iff (!rst_n)
        sts.scan_done |-> cmd.scan_run)
        else $error("scan done outside the scan phase");
`endif

endmodule

/* dv/stanley_path_steering_test.sv */
// Self-checking testbench for the Stanley path-steering block.
// Depends on stps_pkg for the word types, the opcodes and the register indexes.
// It drives path loads and steer words with random stalls and checks every result.
module stanley_path_steering_test;
    import stps_pkg::*;

    localparam int NPTS       = 256;
    localparam int STEPS      = 28;
    localparam int SETTLE     = 400;
    localparam int WDOG_LIMIT = 6000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_ready;
    item_t       item = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    result_t     result;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_GAIN;
    logic [15:0] cfg_data = '0;

    stanley_path_steering uut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready), .item(item),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    // Shadow state of the steering block.
    longint    shadow_x [NPTS];
    longint    shadow_y [NPTS];
    int        shadow_target;
    int        shadow_gain;
    int        shadow_count;
    longint    arctan [STEPS];

    item_t     word_queue [$];
    result_t   steer_queue [$];
    int        words_sent = 0;
    int        words_taken = 0;
    int        errors = 0;
    int        pushed = 0;
    int        wdog = 0;
    bit        quiet = 1'b0;
    int        in_gap = 0;
    int        out_gap = 0;

    // atan(1/n) scaled by 2^61, from the alternating power series.
    function automatic longint unsigned arccot_series(longint unsigned n);
        longint unsigned t, nn, s, k;
        t = (64'd1 << 61) / n;
        nn = n * n;
        s = 0;
        k = 0;
        while (t != 0)
        begin
            if (k[0] == 1'b0)
                s = s + t / (2 * k + 1);
            else
                s = s - t / (2 * k + 1);
            t = t / nn;
            k++;
        end
        return s;
    endfunction

    function automatic longint shift_round(longint v, int s);
        longint half;
        half = longint'(1) << (s - 1);
        if (v >= 0)
            return (v + half) >>> s;
        return -((-v + half) >>> s);
    endfunction

    function automatic longint vec_atan2(longint y, longint x);
        longint z, t, xs, ys;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y; y = -t; z = 2 * arctan[0];
            end
            else
            begin
                x = -y; y = t; z = -2 * arctan[0];
            end
        end
        for (int i = 0; i < STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x += ys; y -= xs; z += arctan[i];
            end
            else
            begin
                x -= ys; y += xs; z -= arctan[i];
            end
        end
        return z;
    endfunction

    function automatic longint rotated_x(longint x, longint y, longint a);
        longint hp, t, xs, ys;
        hp = 2 * arctan[0];
        if (a > hp)
        begin
            t = x; x = -y; y = t; a -= hp;
        end
        else if (a < -hp)
        begin
            t = x; x = y; y = -t; a += hp;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (a >= 0)
            begin
                x -= ys; y += xs; a -= arctan[i];
            end
            else
            begin
                x += ys; y -= xs; a += arctan[i];
            end
        end
        return x;
    endfunction

    // Nearest-point search, heading error and cross-track term for one steer word.
    function automatic result_t steer_command(item_t w);
        result_t r;
        longint px, py, yaw, spd, ex, ey, d, best_d, hdg, th_e, a, pi_i, xr, e8, th_d;
        int n, best, tgt, seg;
        px = w.pos_x;
        py = w.pos_y;
        yaw = w.yaw;
        spd = w.speed;
        n = shadow_count < 2 ? 2 : (shadow_count > NPTS ? NPTS : shadow_count);
        best = 0;
        best_d = 0;
        for (int i = 0; i < n; i++)
        begin
            ex = shadow_x[i] - px;
            ey = shadow_y[i] - py;
            d = ex * ex + ey * ey;
            if (i == 0 || d < best_d)
            begin
                best_d = d;
                best = i;
            end
        end
        tgt = best > shadow_target ? best : shadow_target;
        if (tgt > n - 1)
            tgt = n - 1;
        shadow_target = tgt;
        seg = tgt < n - 1 ? tgt : n - 2;
        hdg = shift_round(vec_atan2(shadow_y[seg + 1] - shadow_y[seg],
                                    shadow_x[seg + 1] - shadow_x[seg]), 15);
        th_e = hdg - yaw;
        while (th_e > 25736) th_e -= 51472;
        while (th_e < -25736) th_e += 51472;
        pi_i = 4 * arctan[0];
        a = -(yaw * 32768 + 2 * arctan[0]);
        while (a > pi_i) a -= 2 * pi_i;
        while (a < -pi_i) a += 2 * pi_i;
        xr = rotated_x((shadow_x[tgt] - px) * 256, (shadow_y[tgt] - py) * 256, a);
        e8 = shift_round(xr * 64'sd652032874, 30);
        th_d = shift_round(vec_atan2(longint'(shadow_gain) * e8, spd * 65536), 15);
        r.steer_angle = 17'(th_e + th_d);
        r.target_index = 8'(tgt);
        return r;
    endfunction

    // Input driver: a new word only once the previous one is taken; result_ready drops for random gaps.
    always @(negedge clk)
    begin
        if (!item_valid || words_taken == words_sent)
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                item_valid <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                in_gap = $urandom_range(0, 14);
                item_valid <= 1'b0;
            end
            else if (word_queue.size() > 0)
            begin
                item <= word_queue.pop_front();
                item_valid <= 1'b1;
                words_sent++;
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
        if (out_gap > 0)
        begin
            out_gap--;
            result_ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            out_gap = $urandom_range(0, 14);
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= 1'b1;
        end
    end

    // Monitor: predicts on accepted words, checks accepted results.
    always @(posedge clk)
    begin
        result_t want;
        bit      active;
        active = 1'b0;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                active = 1'b1;
                if (cfg_index == CFG_GAIN)
                    shadow_gain = cfg_data;
                else
                    shadow_count = cfg_data[8:0];
            end
            if (item_valid && item_ready)
            begin
                active = 1'b1;
                words_taken <= words_taken + 1;
                if (item.op == OP_LOAD)
                begin
                    shadow_x[item.point_index] = item.pos_x;
                    shadow_y[item.point_index] = item.pos_y;
                    shadow_target = 0;
                end
                else
                begin
                    steer_queue.push_back(steer_command(item));
                end
            end
            if (result_valid && result_ready)
            begin
                active = 1'b1;
                if (steer_queue.size() == 0)
                begin
                    $error("unexpected result word: steer_angle %0d target_index %0d",
                           result.steer_angle, result.target_index);
                    errors++;
                end
                else
                begin
                    want = steer_queue.pop_front();
                    if (result.steer_angle !== want.steer_angle)
                    begin
                        $error("steer_angle expected %0d actual %0d",
                               want.steer_angle, result.steer_angle);
                        errors++;
                    end
                    if (result.target_index !== want.target_index)
                    begin
                        $error("target_index expected %0d actual %0d",
                               want.target_index, result.target_index);
                        errors++;
                    end
                end
            end
            wdog <= active ? 0 : wdog + 1;
            if (wdog >= WDOG_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic load_point(int idx, int x, int y);
        item_t w;
        w = '0;
        w.op = OP_LOAD;
        w.point_index = 8'(idx);
        w.pos_x = 20'(x);
        w.pos_y = 20'(y);
        w.yaw = 16'($urandom());
        w.speed = 16'($urandom());
        word_queue.push_back(w);
        pushed++;
    endtask

    task automatic steer_at(int x, int y, int yaw, int spd);
        item_t w;
        w.op = OP_STEER;
        w.point_index = 8'($urandom());
        w.pos_x = 20'(x);
        w.pos_y = 20'(y);
        w.yaw = 16'(yaw);
        w.speed = 16'(spd);
        word_queue.push_back(w);
        pushed++;
    endtask

    // Waits until all words are in and answered, then lets the block settle.
    task automatic drain();
        while (word_queue.size() > 0 || words_taken != words_sent || item_valid ||
               steer_queue.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, int value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 16'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic int any_yaw();
        if ($urandom_range(0, 15) == 0)
            return int'($urandom_range(0, 65535)) - 32768;
        return int'($urandom_range(0, 51472)) - 25736;
    endfunction

    function automatic int any_speed();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return int'($urandom_range(0, 65535)) - 32768;
            default: return int'($urandom_range(0, 3000)) - 500;
        endcase
    endfunction

    initial
    begin
        int n, x, y, k, steps, wide, span;
        int px [NPTS];
        int py [NPTS];
        shadow_target = 0;
        shadow_gain = 256;
        shadow_count = 2;
        begin
            longint unsigned v;
            v = arccot_series(2) + arccot_series(3);
            arctan[0] = longint'((v + (64'd1 << 32)) >> 33);
            for (int i = 1; i < STEPS; i++)
            begin
                v = arccot_series(64'd1 << i);
                arctan[i] = longint'((v + (64'd1 << 32)) >> 33);
            end
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings, two points at opposite corners of the field.
        load_point(0, -524288, -524288);
        load_point(1, 524287, 524287);
        steer_at(-524288, -524288, 0, 0);
        steer_at(524287, -524288, 25736, 32767);
        steer_at(-524288, 524287, -25736, -32768);
        steer_at(0, 0, -32768, 1000);
        steer_at(524287, 524287, 32767, 0);
        // Coincident points give a zero-length segment.
        load_point(0, 100, 100);
        load_point(1, 100, 100);
        steer_at(100, 100, 1234, 0);
        steer_at(90, -300, -4000, 250);
        // Equal distances pick the lower index; the target then never goes back.
        load_point(0, 0, 0);
        load_point(1, 100, 0);
        steer_at(50, 7, 0, 500);
        steer_at(95, 3, 100, 500);
        steer_at(2, 1, 100, 500);
        drain();

        // Long path, full gain: last point reuses the previous segment.
        write_reg(CFG_GAIN, 65535);
        write_reg(CFG_COUNT, 256);
        for (int i = 0; i < NPTS; i++)
            load_point(i, i * 100 - 12800, int'($urandom_range(0, 200)) - 100);
        steer_at(200 * 100 - 12800, 40, 0, 800);
        steer_at(255 * 100 - 12800, -30, 300, 800);
        drain();
        // Smaller count leaves the stored target past the end of the path.
        write_reg(CFG_COUNT, 4);
        steer_at(0, 0, 0, 500);
        drain();
        write_reg(CFG_COUNT, 16'hFE00);
        write_reg(CFG_GAIN, 0);
        steer_at(1000, 500, 200, 300);
        drain();
        write_reg(CFG_COUNT, 1);
        steer_at(-12800, 0, 0, 300);
        drain();
        write_reg(CFG_COUNT, 16'hFFFF);
        steer_at(3000, 10, -100, 300);
        drain();

        k = 0;
        while (pushed < 1800)
        begin
            k++;
            if (pushed > 1550)
                quiet = 1'b1;
            write_reg(CFG_GAIN, $urandom_range(0, 3) == 0 ?
                      ($urandom_range(0, 1) ? 65535 : 0) : $urandom_range(0, 65535));
            n = (k % 12 == 5) ? 256 : $urandom_range(2, 12);
            write_reg(CFG_COUNT, n | ($urandom_range(0, 3) == 0 ? ($urandom() & 16'hFE00) : 0));
            wide = ($urandom_range(0, 3) == 0);
            span = wide ? 0 : $urandom_range(50, 3000);
            x = int'($urandom_range(0, 20000)) - 10000;
            y = int'($urandom_range(0, 20000)) - 10000;
            for (int i = 0; i < n; i++)
            begin
                if (wide)
                begin
                    px[i] = int'(20'sh00000 + signed'(20'($urandom())));
                    py[i] = int'(signed'(20'($urandom())));
                end
                else
                begin
                    x += int'($urandom_range(0, 2 * span)) - span / 2;
                    y += int'($urandom_range(0, 2 * span)) - span;
                    px[i] = x;
                    py[i] = y;
                end
                load_point(i, px[i], py[i]);
            end
            steps = $urandom_range(8, 30);
            for (int s = 0; s < steps; s++)
            begin
                case ($urandom_range(0, 9))
                    0: steer_at(int'(signed'(20'($urandom()))), int'(signed'(20'($urandom()))),
                                any_yaw(), any_speed());
                    1: load_point($urandom_range(0, 255), int'(signed'(20'($urandom()))),
                                  int'(signed'(20'($urandom()))));
                    default:
                    begin
                        int j;
                        j = (s * n) / steps;
                        steer_at(px[j] + int'($urandom_range(0, 400)) - 200,
                                 py[j] + int'($urandom_range(0, 400)) - 200,
                                 any_yaw(), any_speed());
                    end
                endcase
            end
            drain();
            // A stray load may have hit a slot below the count; the loop below copies each shadow entry onto itself.
            for (int i = 0; i < n; i++)
            begin
                shadow_x[i] = shadow_x[i];
            end
        end
        drain();
        if (errors == 0 && steer_queue.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/stps_pkg.sv
hw/rtl/stps_cordic.sv
hw/rtl/stps_ctrl.sv
hw/rtl/stps_dp.sv
hw/rtl/stanley_path_steering.sv
dv/stanley_path_steering_test.sv
